// ===== design/fft16_pkg.sv =====
// ============================================================================
// fft16_pkg
// Shared constants, types and helper functions of the 16-point radix-2 FFT.
// ============================================================================
package fft16_pkg;

  localparam int POINTS    = 16;
  localparam int ADDR_W    = 4;   // address of one work store entry
  localparam int STAGE_W   = 2;   // butterfly stage number, 0..3
  localparam int BF_W      = 3;   // butterfly number within a stage, 0..7
  localparam int SAMPLE_W  = 16;
  localparam int DATA_W    = 21;
  localparam int WORD_W    = 2 * DATA_W;
  localparam int TW_W      = 18;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = DATA_W + TW_W;
  localparam int RND_W     = PROD_W + 1 - FRAC_W;

  localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(POINTS - 1);
  localparam logic [BF_W-1:0]    BF_LAST    = '1;
  localparam logic [STAGE_W-1:0] STAGE_LAST = '1;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_SUM,
    WSEL_DIFF
  } wsel_t;

  typedef struct packed {
    logic              we;
    wsel_t             wsel;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_ctrl_t;

  typedef struct packed {
    logic            mul_en;
    logic            sum_en;
    logic [BF_W-1:0] tw_idx;
  } bf_ctrl_t;

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int k = 0; k < ADDR_W; k++) begin
      r[k] = v[ADDR_W-1-k];
    end
    return r;
  endfunction

  // Upper entry of butterfly n in stage s: a zero bit inserted at position s.
  function automatic logic [ADDR_W-1:0] bf_top(input logic [BF_W-1:0] n,
                                               input logic [STAGE_W-1:0] s);
    logic [ADDR_W-1:0] nx;
    logic [ADDR_W-1:0] low_mask;
    nx       = {1'b0, n};
    low_mask = ~({ADDR_W{1'b1}} << s);
    return ((nx & ~low_mask) << 1) | (nx & low_mask);
  endfunction

  // Lower entry lies half a span below the upper one.
  function automatic logic [ADDR_W-1:0] bf_bot(input logic [BF_W-1:0] n,
                                               input logic [STAGE_W-1:0] s);
    return bf_top(n, s) | (ADDR_W'(1) << s);
  endfunction

  function automatic logic [BF_W-1:0] bf_tw(input logic [BF_W-1:0] n,
                                            input logic [STAGE_W-1:0] s);
    logic [BF_W-1:0] j;
    j = n & ~({BF_W{1'b1}} << s);
    return j << (STAGE_W'(BF_W) - s);
  endfunction

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [BF_W-1:0] idx);
    logic signed [TW_W-1:0] v;
    case (idx)
      3'd0:    v = 18'sd65536;
      3'd1:    v = 18'sd60547;
      3'd2:    v = 18'sd46341;
      3'd3:    v = 18'sd25080;
      3'd4:    v = 18'sd0;
      3'd5:    v = -18'sd25080;
      3'd6:    v = -18'sd46341;
      3'd7:    v = -18'sd60547;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] tw_sin(input logic [BF_W-1:0] idx);
    logic signed [TW_W-1:0] v;
    case (idx)
      3'd0:    v = 18'sd0;
      3'd1:    v = -18'sd25080;
      3'd2:    v = -18'sd46341;
      3'd3:    v = -18'sd60547;
      3'd4:    v = -18'sd65536;
      3'd5:    v = -18'sd60547;
      3'd6:    v = -18'sd46341;
      3'd7:    v = -18'sd25080;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/fft16_ram.sv =====
// ============================================================================
// fft16_ram
// Generic synchronous RAM, one write port and two registered read ports.
// ============================================================================
module fft16_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while no read is issued.
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/fft16_bfly.sv =====
// ============================================================================
// fft16_bfly
// Radix-2 butterfly datapath: registered twiddle products, then sum and
// difference with round-to-nearest on each product.
// ============================================================================
module fft16_bfly
  import fft16_pkg::*;
(
  input  logic              clk,
  input  bf_ctrl_t          bf,
  input  logic [WORD_W-1:0] rd_a,
  input  logic [WORD_W-1:0] rd_b,
  output logic [WORD_W-1:0] sum_word,
  output logic [WORD_W-1:0] diff_word
);

  logic signed [DATA_W-1:0] b_re;
  logic signed [DATA_W-1:0] b_im;
  logic signed [TW_W-1:0]   tw_c;
  logic signed [TW_W-1:0]   tw_s;

  logic signed [DATA_W-1:0] a_re_r;
  logic signed [DATA_W-1:0] a_im_r;
  logic signed [PROD_W-1:0] p_rc_r;
  logic signed [PROD_W-1:0] p_is_r;
  logic signed [PROD_W-1:0] p_ic_r;
  logic signed [PROD_W-1:0] p_rs_r;

  logic signed [RND_W-1:0]  t_re;
  logic signed [RND_W-1:0]  t_im;
  logic signed [RND_W-1:0]  sum_re;
  logic signed [RND_W-1:0]  sum_im;
  logic signed [RND_W-1:0]  dif_re;
  logic signed [RND_W-1:0]  dif_im;
  logic [WORD_W-1:0]        diff_r;

  // Adds one half and floors by the fraction width.
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] q;
    q = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (FRAC_W - 1));
    return RND_W'(q >>> FRAC_W);
  endfunction

  assign b_re = $signed(rd_b[WORD_W-1:DATA_W]);
  assign b_im = $signed(rd_b[DATA_W-1:0]);
  assign tw_c = tw_cos(bf.tw_idx);
  assign tw_s = tw_sin(bf.tw_idx);

  always_ff @(posedge clk) begin
    if (bf.mul_en) begin
      a_re_r <= $signed(rd_a[WORD_W-1:DATA_W]);
      a_im_r <= $signed(rd_a[DATA_W-1:0]);
      p_rc_r <= b_re * tw_c;
      p_is_r <= b_im * tw_s;
      p_ic_r <= b_im * tw_c;
      p_rs_r <= b_re * tw_s;
    end
    if (bf.sum_en) begin
      diff_r <= {DATA_W'(dif_re), DATA_W'(dif_im)};
    end
  end

  always_comb begin
    t_re   = rnd(p_rc_r) - rnd(p_is_r);
    t_im   = rnd(p_ic_r) + rnd(p_rs_r);
    sum_re = RND_W'(a_re_r) + t_re;
    sum_im = RND_W'(a_im_r) + t_im;
    dif_re = RND_W'(a_re_r) - t_re;
    dif_im = RND_W'(a_im_r) - t_im;
  end

  assign sum_word  = {DATA_W'(sum_re), DATA_W'(sum_im)};
  assign diff_word = diff_r;

endmodule

// ===== design/fft16_ctrl.sv =====
// ============================================================================
// fft16_ctrl
// Sequencer: sample load, butterfly passes and bin read-out with the
// output handshake.
// ============================================================================
module fft16_ctrl
  import fft16_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_bin_index,
  output logic              out_last_bin,
  output logic              emit_load,
  output mem_ctrl_t         mem,
  output bf_ctrl_t          bf
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_WA,
    ST_BF_WB,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  state_t             state_r,      state_nxt;
  logic [ADDR_W-1:0]  load_cnt_r,   load_cnt_nxt;
  logic [STAGE_W-1:0] stage_r,      stage_nxt;
  logic [BF_W-1:0]    bf_cnt_r,     bf_cnt_nxt;
  logic [ADDR_W-1:0]  emit_cnt_r,   emit_cnt_nxt;
  logic               pend_r,       pend_nxt;
  logic               out_valid_r,  out_valid_nxt;
  logic [ADDR_W-1:0]  bin_index_r,  bin_index_nxt;
  logic               last_r,       last_nxt;
  logic               out_free;
  logic [BF_W-1:0]    bf_next;

  assign out_free = !out_valid_r || out_ready;
  assign bf_next  = bf_cnt_r + BF_W'(1);

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    stage_nxt     = stage_r;
    bf_cnt_nxt    = bf_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    bin_index_nxt = bin_index_r;
    last_nxt      = last_r;
    emit_load     = 1'b0;
    in_ready      = 1'b0;

    mem.we      = 1'b0;
    mem.wsel    = WSEL_LOAD;
    mem.waddr   = bit_rev(load_cnt_r);
    mem.re      = 1'b0;
    mem.raddr_a = bf_top(bf_cnt_r, stage_r);
    mem.raddr_b = bf_bot(bf_cnt_r, stage_r);

    bf.mul_en = 1'b0;
    bf.sum_en = 1'b0;
    bf.tw_idx = bf_tw(bf_cnt_r, stage_r);

    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem.we       = 1'b1;
          load_cnt_nxt = load_cnt_r + ADDR_W'(1);
          if (load_cnt_r == ADDR_LAST) begin
            stage_nxt  = '0;
            bf_cnt_nxt = '0;
            state_nxt  = ST_BF_RD;
          end
        end
      end
      ST_BF_RD: begin
        mem.re    = 1'b1;
        state_nxt = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        bf.mul_en = 1'b1;
        state_nxt = ST_BF_WA;
      end
      ST_BF_WA: begin
        bf.sum_en = 1'b1;
        mem.we    = 1'b1;
        mem.wsel  = WSEL_SUM;
        mem.waddr = bf_top(bf_cnt_r, stage_r);
        state_nxt = ST_BF_WB;
      end
      ST_BF_WB: begin
        mem.we    = 1'b1;
        mem.wsel  = WSEL_DIFF;
        mem.waddr = bf_bot(bf_cnt_r, stage_r);
        if (bf_cnt_r != BF_LAST) begin
          // Butterflies of one stage touch disjoint entries, so the next
          // read may overlap this write.
          mem.re      = 1'b1;
          mem.raddr_a = bf_top(bf_next, stage_r);
          mem.raddr_b = bf_bot(bf_next, stage_r);
          bf_cnt_nxt  = bf_next;
          state_nxt   = ST_BF_MUL;
        end else if (stage_r != STAGE_LAST) begin
          bf_cnt_nxt = '0;
          stage_nxt  = stage_r + STAGE_W'(1);
          state_nxt  = ST_BF_RD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        mem.re       = 1'b1;
        mem.raddr_a  = '0;
        emit_cnt_nxt = '0;
        pend_nxt     = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (pend_r && out_free) begin
          emit_load     = 1'b1;
          out_valid_nxt = 1'b1;
          bin_index_nxt = emit_cnt_r;
          last_nxt      = (emit_cnt_r == ADDR_LAST);
          if (emit_cnt_r != ADDR_LAST) begin
            mem.re       = 1'b1;
            mem.raddr_a  = emit_cnt_r + ADDR_W'(1);
            emit_cnt_nxt = emit_cnt_r + ADDR_W'(1);
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      stage_r     <= '0;
      bf_cnt_r    <= '0;
      emit_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bin_index_r <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stage_r     <= stage_nxt;
      bf_cnt_r    <= bf_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      bin_index_r <= bin_index_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = bin_index_r;
  assign out_last_bin  = last_r;

endmodule

// ===== design/fft16_radix2_dit_unit.sv =====
// ============================================================================
// fft16_radix2_dit_unit
// 16-point radix-2 decimation-in-time FFT in fixed point, built around one
// work store RAM and one shared butterfly.
// ============================================================================
// The 16 bins leave, once the sixteenth sample word is accepted and the
// butterfly passes have run, one per cycle while out_ready is high. A
// transform runs sample load, butterfly passes and bin read-out in turn; no
// new sample word is accepted until the read-out of the previous one ends.
// Reset: rst_n is synchronous and active low; it clears the sequencer and the
// output valid flag, while the work store keeps its contents.
module fft16_radix2_dit_unit
  import fft16_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_re,
  input  logic signed [SAMPLE_W-1:0] in_sample_im,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   out_bin_re,
  output logic signed [DATA_W-1:0]   out_bin_im,
  output logic [ADDR_W-1:0]          out_bin_index,
  output logic                       out_last_bin
);

  // Each sample word is written straight into the work store at the
  // bit-reversed position of its arrival count, so the butterfly passes can
  // run in place and the bins come out of the store in natural order.
  //
  // The store holds the real part in the upper half of each entry and the
  // imaginary part in the lower half. Its two read ports fetch both inputs of
  // a butterfly together; the single write port writes the sum and, in the
  // cycle after, the difference. A butterfly therefore runs through three
  // states (multiply, write sum, write difference), the read of the next one
  // overlapping the difference write. Between stages an extra read state is
  // passed, because the first butterfly of a stage can use an entry that the
  // last butterfly of the previous stage is still writing.

  mem_ctrl_t         mem;
  bf_ctrl_t          bf;
  logic              emit_load;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] sum_word;
  logic [WORD_W-1:0] diff_word;
  logic [WORD_W-1:0] load_word;
  logic [WORD_W-1:0] wdata;
  logic signed [DATA_W-1:0] bin_re_r;
  logic signed [DATA_W-1:0] bin_im_r;

  fft16_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_bin_index (out_bin_index),
    .out_last_bin  (out_last_bin),
    .emit_load     (emit_load),
    .mem           (mem),
    .bf            (bf)
  );

  // Samples are sign-extended to the full growth width on entry.
  assign load_word = {DATA_W'(in_sample_re), DATA_W'(in_sample_im)};

  always_comb begin
    case (mem.wsel)
      WSEL_LOAD: wdata = load_word;
      WSEL_SUM:  wdata = sum_word;
      WSEL_DIFF: wdata = diff_word;
      default:   wdata = load_word;
    endcase
  end

  fft16_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POINTS)
  ) u_work (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (wdata),
    .re      (mem.re),
    .raddr_a (mem.raddr_a),
    .raddr_b (mem.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  fft16_bfly u_bfly (
    .clk       (clk),
    .bf        (bf),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .sum_word  (sum_word),
    .diff_word (diff_word)
  );

  // Output register: the sequencer loads it from the first read port when
  // the slot is empty or its word is being taken in the same cycle, so the
  // bins stream without a gap while the consumer keeps out_ready high.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      bin_re_r <= $signed(rd_a[WORD_W-1:DATA_W]);
      bin_im_r <= $signed(rd_a[DATA_W-1:0]);
    end
  end

  assign out_bin_re = bin_re_r;
  assign out_bin_im = bin_im_r;

endmodule

// ===== design/fft16_checker.sv =====
// ============================================================================
// fft16_checker
// Port-level assertions for the FFT unit, bound to its top level.
// ============================================================================
module fft16_checker
  import fft16_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [DATA_W-1:0]   out_bin_re,
  input logic signed [DATA_W-1:0]   out_bin_im,
  input logic [ADDR_W-1:0]          out_bin_index,
  input logic                       out_last_bin
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_re) &&
      $stable(out_bin_im) && $stable(out_bin_index) && $stable(out_last_bin))
    else $error("stalled result word changed");

  // The flag marks the final bin and only that one.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_bin == (out_bin_index == ADDR_LAST)))
    else $error("last flag does not match bin 15");

  // Bins of one transform leave in natural order.
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_bin |=>
      !out_valid || out_bin_index == ADDR_W'($past(out_bin_index) + ADDR_W'(1)))
    else $error("bin index out of order");

  // No result is shown after a reset cycle.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fft16_radix2_dit_unit fft16_checker u_fft16_checker (.*);
